// ===== hdl/tgdw_pkg.sv =====
// Shared types and constants for the text glyph display writer.
// Holds the 5x7 font table, the job descriptor and the line-advance helper.
// No dependencies.
`default_nettype none

package tgdw_pkg;

  // Configuration register indexes
  localparam logic CFG_PANEL_WIDTH = 1'b0;
  localparam logic CFG_LINE_COUNT  = 1'b1;

  localparam logic [7:0] PANEL_WIDTH_RESET = 8'd128;
  localparam logic [3:0] LINE_COUNT_RESET  = 4'd8;

  // Character codes with special handling
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_FIRST = 8'h20;

  localparam logic [7:0] COLUMN_STEP = 8'd6;
  localparam logic [8:0] GLYPH_SPAN  = 9'd5;

  // Serializer steps: 0..4 glyph columns, blank, then the three cursor commands
  localparam logic [3:0] STEP_BLANK = 4'd5;
  localparam logic [3:0] STEP_PAGE  = 4'd6;
  localparam logic [3:0] STEP_COLHI = 4'd7;
  localparam logic [3:0] STEP_COLLO = 4'd8;

  localparam logic [3:0] PAGE_CMD  = 4'hB;
  localparam logic [3:0] COLHI_CMD = 4'h1;
  localparam logic [3:0] COLLO_CMD = 4'h0;

  typedef enum logic [1:0] {
    JOB_CURSOR,
    JOB_CHAR,
    JOB_CHAR_WRAP
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [6:0] glyph_idx;
    logic [2:0] line;
    logic [7:0] column;
  } job_t;

  // Column 0 of each glyph sits in the top byte
  localparam logic [39:0] FONT_ROM [96] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
  };

  // (line + 1) mod count, count clamped to 1..8; at most eight subtract steps
  function automatic logic [2:0] next_line(input logic [2:0] line, input logic [3:0] count);
    logic [3:0] n;
    logic [3:0] v;
    n = count;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'd8)  n = 4'd8;
    v = {1'b0, line} + 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (v >= n) v = v - n;
    end
    return v[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tgdw_emit.sv =====
// Byte serializer: holds one job, reads its glyph from the font ROM and
// sends up to nine words through a registered output stage. Uses tgdw_pkg.
`default_nettype none

module tgdw_emit
  import tgdw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_load,
  input  wire job_t       job,
  output logic            job_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            is_command,
  output logic [7:0]      out_byte,
  output logic            last
);

  logic        busy;
  logic [3:0]  step;
  logic [3:0]  last_step;
  logic [39:0] glyph;
  logic [2:0]  line;
  logic [7:0]  column;
  logic        advance;
  logic        at_end;
  logic [7:0]  cur_byte;

  assign advance   = !out_valid || out_ready;
  assign at_end    = (step == last_step);
  assign job_ready = !busy || (advance && at_end);

  always_comb begin
    case (step)
      4'd0:       cur_byte = glyph[39:32];
      4'd1:       cur_byte = glyph[31:24];
      4'd2:       cur_byte = glyph[23:16];
      4'd3:       cur_byte = glyph[15:8];
      4'd4:       cur_byte = glyph[7:0];
      STEP_PAGE:  cur_byte = {PAGE_CMD, 1'b0, line};
      STEP_COLHI: cur_byte = {COLHI_CMD, column[7:4]};
      STEP_COLLO: cur_byte = {COLLO_CMD, column[3:0]};
      default:    cur_byte = 8'h00;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (job_load) begin
        busy <= 1'b1;
      end else if (advance && busy && at_end) begin
        busy <= 1'b0;
      end
    end
  end

  // Payload; font ROM read is registered here on load
  always_ff @(posedge clk) begin
    if (advance && busy) begin
      is_command <= (step > STEP_BLANK);
      out_byte   <= cur_byte;
      last       <= at_end;
    end
    if (job_load) begin
      step      <= (job.kind == JOB_CURSOR) ? STEP_PAGE : 4'd0;
      last_step <= (job.kind == JOB_CHAR) ? STEP_BLANK : STEP_COLLO;
      glyph     <= FONT_ROM[job.glyph_idx];
      line      <= job.line;
      column    <= job.column;
    end else if (advance && busy) begin
      step <= step + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/text_glyph_display_writer_unit.sv =====
// Top level of the text glyph display writer: config registers, cursor
// state and operation decode; serialization lives in tgdw_emit. Uses tgdw_pkg.
`default_nettype none

// Turns character writes and set-cursor operations into the byte stream of a
// page-addressed monochrome display controller. Each output word carries a
// byte, an is_command flag (command vs. display data) and last, set on the
// final word caused by one input word. A set-cursor, carriage return or line
// feed produces 3 command words; a printable character (0x20..0x7F) produces
// 5 glyph columns plus a blank column, 6 words, or 9 when the column passes
// panel_width - 5 and a cursor command to the next line follows. Other
// control codes and codes at or above 0x80 are taken and produce nothing.
// Throughput is one output word per clock while out_ready is held high, set by
// the serializer that walks a job through its bytes. The cursor is updated and
// the glyph is fetched from the registered font ROM when an item is taken, so
// the next item is accepted in the same cycle that the previous item's last
// word moves into the output register. Configuration writes are always taken
// and apply to items accepted afterwards.
module text_glyph_display_writer_unit
  import tgdw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [7:0] char_code,
  input  wire logic [6:0] cursor_column,
  input  wire logic [2:0] cursor_line,
  // output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            is_command,
  output logic [7:0]      out_byte,
  output logic            last
);

  logic [7:0] panel_width;
  logic [3:0] line_count;
  logic [7:0] column_pos;
  logic [2:0] line_pos;

  logic [7:0] column_pos_next;
  logic [2:0] line_pos_next;
  logic [7:0] column_adv;
  logic [2:0] line_adv;
  logic       wrap;
  logic       emit;
  logic       accept;
  logic       job_ready;
  job_t       job;

  assign cfg_ready = 1'b1;
  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width <= PANEL_WIDTH_RESET;
      line_count  <= LINE_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PANEL_WIDTH: panel_width <= cfg_data;
        CFG_LINE_COUNT:  line_count  <= cfg_data[3:0];
        default:         ;
      endcase
    end
  end

  // Character advance: wrap when column + 6 > width - 5 (signed in effect,
  // so narrow panels wrap every character); written as (col + 6) + 5 > width.
  assign column_adv = column_pos + COLUMN_STEP;
  assign wrap       = ({1'b0, column_adv} + GLYPH_SPAN) > {1'b0, panel_width};
  assign line_adv   = next_line(line_pos, line_count);

  always_comb begin
    column_pos_next = column_pos;
    line_pos_next   = line_pos;
    emit            = 1'b0;
    job.kind        = JOB_CURSOR;
    job.glyph_idx   = char_code[6:0] - CHAR_FIRST[6:0];
    if (op) begin
      column_pos_next = {1'b0, cursor_column};
      line_pos_next   = cursor_line;
      emit            = 1'b1;
    end else if (char_code[7]) begin
      emit = 1'b0;  // high codes dropped
    end else if (char_code == CHAR_CR) begin
      column_pos_next = 8'd0;
      emit            = 1'b1;
    end else if (char_code == CHAR_LF) begin
      line_pos_next = line_adv;
      emit          = 1'b1;
    end else if (char_code < CHAR_FIRST) begin
      emit = 1'b0;  // other control codes dropped
    end else begin
      emit = 1'b1;
      if (wrap) begin
        column_pos_next = 8'd0;
        line_pos_next   = line_adv;
        job.kind        = JOB_CHAR_WRAP;
      end else begin
        column_pos_next = column_adv;
        job.kind        = JOB_CHAR;
      end
    end
    // cursor bytes report the state this item leaves behind
    job.line   = line_pos_next;
    job.column = column_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= 8'd0;
      line_pos   <= 3'd0;
    end else if (accept) begin
      column_pos <= column_pos_next;
      line_pos   <= line_pos_next;
    end
  end

  tgdw_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_load   (accept && emit),
    .job        (job),
    .job_ready  (job_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_command (is_command),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== hdl/tgdw_check.sv =====
// Port-level checks for the text glyph display writer and the bind that
// attaches them to text_glyph_display_writer_unit. No package needed.
`default_nettype none

module tgdw_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       is_command,
  input wire logic [7:0] out_byte,
  input wire logic       last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(is_command) && $stable(last))
    else $error("output word changed while stalled");

  // a command sequence always ends on the low-nibble column command
  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command && last |-> out_byte[7:4] == 4'h0)
    else $error("last command word is not a low column command");

  // a character without a trailing cursor ends on the blank column
  a_data_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_command && last |-> out_byte == 8'h00)
    else $error("last data word is not blank");

  // page command never ends an item
  a_page_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command && out_byte[7:4] == 4'hB |-> !last)
    else $error("page command flagged last");

  // after a taken page command comes the column high command
  a_page_then_hi: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_command && out_byte[7:4] == 4'hB ##1 out_valid
      |-> is_command && out_byte[7:4] == 4'h1)
    else $error("page command not followed by column high command");

endmodule

bind text_glyph_display_writer_unit tgdw_check u_tgdw_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .is_command (is_command),
  .out_byte   (out_byte),
  .last       (last)
);

`default_nettype wire

// ===== bench/text_glyph_display_writer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_glyph_display_writer_unit: random and directed
// character / set-cursor words against an in-bench model of the byte stream.
// Depends on tgdw_pkg (register indexes, special character codes) and the DUT.

module text_glyph_display_writer_unit_tb;
  import tgdw_pkg::*;

  typedef enum logic {
    OP_WRITE_CHAR = 1'b0,
    OP_SET_CURSOR = 1'b1
  } op_kind_t;

  // one input word
  typedef struct packed {
    op_kind_t   op;
    logic [7:0] code;
    logic [6:0] col;
    logic [2:0] line;
  } text_op_t;

  // one output word
  typedef struct packed {
    logic       is_cmd;
    logic [7:0] data;
    logic       last;
  } panel_byte_t;

  localparam logic [7:0] CHAR_TOP       = 8'h7F;  // highest printable code
  localparam logic [7:0] CHAR_HIGH      = 8'h80;  // this and above are dropped
  localparam logic [7:0] PAGE_CMD_BASE  = 8'hB0;
  localparam logic [7:0] COLHI_CMD_BASE = 8'h10;
  localparam logic [7:0] BLANK_COLUMN   = 8'h00;
  localparam int         GLYPH_ADVANCE  = 6;
  localparam int         WRAP_MARGIN    = 5;

  localparam int SETTLE_CYCLES  = 20;      // covers a dropped code still in flight
  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEMS_PER_PASS = 29;      // counted words per random phase
  localparam int NUM_PHASES     = 8;
  localparam int REPORT_LIMIT   = 10;

  // 5-column glyphs for 0x20..0x7F, leftmost column in the top byte
  localparam logic [39:0] GLYPH_BITS [96] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
  };

  // every DUT input starts at a known value
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_PANEL_WIDTH;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = OP_WRITE_CHAR;
  logic [7:0] char_code = 8'h00;
  logic [6:0] cursor_column = 7'd0;
  logic [2:0] cursor_line = 3'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_command;
  logic [7:0] out_byte;
  logic       last;

  text_glyph_display_writer_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .char_code     (char_code),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_command    (is_command),
    .out_byte      (out_byte),
    .last          (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Writer model: mirrors the cursor and the two config registers, and turns
  // every accepted input word into the bytes the controller should receive.
  // ---------------------------------------------------------------------------
  logic [7:0]  width_reg  = PANEL_WIDTH_RESET;
  logic [3:0]  lines_reg  = LINE_COUNT_RESET;
  logic [7:0]  cur_column = 8'd0;
  logic [2:0]  cur_line   = 3'd0;
  panel_byte_t staged[$];          // bytes of the word being modeled
  panel_byte_t expected_bytes[$];  // bytes still owed by the DUT
  int          mismatch_count = 0;

  // line + 1, wrapping at the line count; count 0 acts as 1, above 8 as 8
  function automatic logic [2:0] advance_line(input logic [2:0] ln, input logic [3:0] cnt);
    int n;
    n = cnt;
    if (n == 0) n = 1;
    if (n > 8) n = 8;
    return 3'((int'(ln) + 1) % n);
  endfunction

  task automatic stage_byte(input logic is_cmd, input logic [7:0] data);
    panel_byte_t w;
    w.is_cmd = is_cmd;
    w.data   = data;
    w.last   = 1'b0;
    staged.push_back(w);
  endtask

  task automatic stage_cursor();
    stage_byte(1'b1, PAGE_CMD_BASE + {5'd0, cur_line});
    stage_byte(1'b1, COLHI_CMD_BASE + {4'd0, cur_column[7:4]});
    stage_byte(1'b1, {4'd0, cur_column[3:0]});
  endtask

  task automatic render_item(input logic op_i, input logic [7:0] code,
                             input logic [6:0] col, input logic [2:0] ln);
    logic [39:0] glyph;
    panel_byte_t w;
    staged.delete();
    if (op_i == OP_SET_CURSOR) begin
      // line is kept as given even past the line count
      cur_column = {1'b0, col};
      cur_line   = ln;
      stage_cursor();
    end else if (code >= CHAR_HIGH) begin
      // dropped
    end else if (code == CHAR_CR) begin
      cur_column = 8'd0;
      stage_cursor();
    end else if (code == CHAR_LF) begin
      cur_line = advance_line(cur_line, lines_reg);
      stage_cursor();
    end else if (code < CHAR_FIRST) begin
      // other control codes dropped too
    end else begin
      glyph = GLYPH_BITS[7'(code - CHAR_FIRST)];
      for (int i = 0; i < 5; i++) stage_byte(1'b0, glyph[39 - 8*i -: 8]);
      stage_byte(1'b0, BLANK_COLUMN);
      // 8-bit column rolls over; the wrap test is signed so tiny widths
      // wrap after every glyph
      cur_column = cur_column + 8'(GLYPH_ADVANCE);
      if (int'(cur_column) > int'(width_reg) - WRAP_MARGIN) begin
        cur_column = 8'd0;
        cur_line   = advance_line(cur_line, lines_reg);
        stage_cursor();
      end
    end
    for (int i = 0; i < staged.size(); i++) begin
      w = staged[i];
      w.last = (i == staged.size() - 1);
      expected_bytes.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pops pending words, bursts with random gaps when enabled.
  // Prediction runs at the acceptance edge, from the payload on the pins.
  // ---------------------------------------------------------------------------
  text_op_t pending_ops[$];
  text_op_t next_op;
  bit       sender_idle = 1'b1;
  int       burst_left  = 4;
  int       gap_left    = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) render_item(op, char_code, cursor_column, cursor_line);
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          op            <= next_op.op;
          char_code     <= next_op.code;
          cursor_column <= next_op.col;
          cursor_line   <= next_op.line;
          in_valid      <= 1'b1;
          if (sender_idle) begin
            burst_left--;
            if (burst_left <= 0) begin
              gap_left   = $urandom_range(1, 6);
              burst_left = $urandom_range(1, 30);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each accepted byte against the oldest expectation.
  // recv_mode 0 never stalls, 1 stalls briefly and often, 2 stalls long.
  // ---------------------------------------------------------------------------
  int          recv_mode  = 1;
  int          stall_left = 0;
  panel_byte_t got_byte;
  panel_byte_t want_byte;

  task automatic note_mismatch(input string what, input panel_byte_t want,
                               input panel_byte_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%s: want cmd=%0b byte=%02h last=%0b, got cmd=%0b byte=%02h last=%0b",
               what, want.is_cmd, want.data, want.last, got.is_cmd, got.data, got.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_byte.is_cmd = is_command;
        got_byte.data   = out_byte;
        got_byte.last   = last;
        if (expected_bytes.size() == 0) begin
          note_mismatch("unexpected word", '0, got_byte);
        end else begin
          want_byte = expected_bytes.pop_front();
          if (got_byte.is_cmd !== want_byte.is_cmd || got_byte.data !== want_byte.data ||
              got_byte.last !== want_byte.last)
            note_mismatch("word mismatch", want_byte, got_byte);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_mode == 1 && $urandom_range(0, 99) < 35) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else if (recv_mode == 2 && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(3, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(input op_kind_t o, input logic [7:0] c,
                          input logic [6:0] col, input logic [2:0] ln);
    text_op_t t;
    t.op   = o;
    t.code = c;
    t.col  = col;
    t.line = ln;
    pending_ops.push_back(t);
  endtask

  // Mostly printable runs broken up by cursor moves, CR and LF; some noise.
  // All fields are random so the ignored ones toggle too.
  function automatic text_op_t random_op();
    text_op_t    t;
    int unsigned pick;
    t.op   = OP_WRITE_CHAR;
    t.code = 8'($urandom_range(0, 255));
    t.col  = 7'($urandom_range(0, 127));
    t.line = 3'($urandom_range(0, 7));
    pick   = $urandom_range(0, 99);
    if (pick < 12)      t.op = OP_SET_CURSOR;
    else if (pick < 18) t.code = CHAR_CR;
    else if (pick < 24) t.code = CHAR_LF;
    else if (pick < 30) t.code = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF))
                                                      : 8'($urandom_range(0, 8'h1F));
    else                t.code = 8'($urandom_range(CHAR_FIRST, CHAR_TOP));
    return t;
  endfunction

  // true if the word produces bytes (dropped codes do not count as work)
  function automatic bit makes_bytes(input text_op_t t);
    return t.op == OP_SET_CURSOR || t.code == CHAR_CR || t.code == CHAR_LF ||
           (t.code >= CHAR_FIRST && t.code < CHAR_HIGH);
  endfunction

  // Sender holds off until the queue is empty and every byte is back, then
  // gives a dropped code time to leave the pipe.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    if (idx == CFG_PANEL_WIDTH) width_reg = data;
    else lines_reg = data[3:0];
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         counted;
    int         pw;
    int         lc;
    text_op_t   t;
    logic [3:0] junk;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset settings (width 128, 8 lines)
    queue_op(OP_SET_CURSOR, 8'hFF, 7'd127, 3'd7);  // far corner
    queue_op(OP_WRITE_CHAR, 8'h41, 7'd0, 3'd0);    // past the edge: wrap, line 7 -> 0
    queue_op(OP_WRITE_CHAR, CHAR_FIRST, 7'd127, 3'd7);
    queue_op(OP_WRITE_CHAR, CHAR_TOP, 7'd0, 3'd0);
    queue_op(OP_WRITE_CHAR, CHAR_CR, 7'd0, 3'd0);
    queue_op(OP_WRITE_CHAR, CHAR_LF, 7'd0, 3'd0);
    queue_op(OP_WRITE_CHAR, 8'h00, 7'd0, 3'd0);    // dropped control codes
    queue_op(OP_WRITE_CHAR, 8'h1F, 7'd0, 3'd0);
    queue_op(OP_WRITE_CHAR, CHAR_HIGH, 7'd0, 3'd0); // dropped high codes
    queue_op(OP_WRITE_CHAR, 8'hFF, 7'd0, 3'd0);
    queue_op(OP_SET_CURSOR, 8'h00, 7'd0, 3'd0);
    queue_op(OP_SET_CURSOR, 8'hAA, 7'h55, 3'd2);
    queue_op(OP_WRITE_CHAR, 8'h55, 7'h2A, 3'd5);
    queue_op(OP_WRITE_CHAR, 8'h2A, 7'h55, 3'd2);
    queue_op(OP_WRITE_CHAR, CHAR_LF, 7'd0, 3'd0);
    wait_drained();

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      // phase settings: extremes first, then a couple of random in-range ones
      case (ph)
        1: begin pw = 6;   lc = 3;  end
        2: begin pw = 255; lc = 15; end  // count above eight, column rollover
        3: begin pw = 128; lc = 8;  end
        4: begin pw = 0;   lc = 0;  end  // zero lines, wrap after every glyph
        5: begin pw = 40;  lc = 1;  end
        6: begin pw = 3;   lc = 9;  end
        default: begin pw = $urandom_range(6, 128); lc = $urandom_range(1, 8); end
      endcase
      junk = 4'($urandom_range(0, 15));  // upper data bits are ignored
      write_reg(CFG_PANEL_WIDTH, 8'(pw));
      write_reg(CFG_LINE_COUNT, {junk, 4'(lc)});

      // phase 3 runs with no idling at either end
      sender_idle = (ph != 3);
      gap_left    = 0;
      recv_mode   = (ph == 3) ? 0 : (ph % 2 == 1) ? 1 : 2;

      counted = 0;
      if (ph == 1) begin
        // cursor line beyond the line count, then wraps on a narrow panel
        queue_op(OP_SET_CURSOR, 8'h00, 7'd0, 3'd6);
        queue_op(OP_WRITE_CHAR, CHAR_LF, 7'd0, 3'd0);
        queue_op(OP_WRITE_CHAR, 8'h78, 7'd0, 3'd0);
        queue_op(OP_WRITE_CHAR, 8'h7E, 7'd0, 3'd0);
        queue_op(OP_SET_CURSOR, 8'h00, 7'd5, 3'd5);
        queue_op(OP_WRITE_CHAR, 8'h42, 7'd0, 3'd0);
      end
      if (ph == 2) begin
        // column 124 + 21 glyphs lands on 250, the next one rolls past 255 to 0
        queue_op(OP_SET_CURSOR, 8'($urandom_range(0, 255)), 7'd124, 3'($urandom_range(0, 7)));
        for (int i = 0; i < 22; i++)
          queue_op(OP_WRITE_CHAR, 8'($urandom_range(CHAR_FIRST, CHAR_TOP)),
                   7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
        counted = 23;
      end
      while (counted < ITEMS_PER_PASS) begin
        // mid-phase pause: let every owed byte come back before going on
        if (ph == 4 && counted == ITEMS_PER_PASS / 2) wait_drained();
        t = random_op();
        pending_ops.push_back(t);
        if (makes_bytes(t)) counted++;
      end
      wait_drained();
    end

    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
